### hdl/srq_pkg.sv
`default_nettype none

package srq_pkg;

   // queue between the front and the back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // arithmetic pipeline depths: one quotient bit, one root bit per stage
   localparam int DIV_STEPS  = 64;
   localparam int SQRT_STEPS = 32;

   localparam logic [1:0] CORNER_LAST = 2'd3;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
      logic signed [31:0] half_width;
   } req_type;

   typedef struct packed {
      logic signed [31:0] corner_x;
      logic signed [31:0] corner_y;
      logic signed [31:0] corner_z;
      logic [1:0]         corner_index;
      logic               valid_res;
      logic               last;
   } rsp_type;

   // coordinates and signs carried alongside the arithmetic
   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] sz;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic signed [31:0] ez;
      logic               ok;
      logic               neg_ox;
      logic               neg_oy;
   } base_type;

   // classified item in the queue
   typedef struct packed {
      base_type    base;
      logic [30:0] ax;
      logic [30:0] ay;
      logic [30:0] w;
   } job_type;

   // restoring divider lane: partial remainder and dividend/quotient shifter
   typedef struct packed {
      logic [62:0] r;
      logic [63:0] qr;
   } div_lane_type;

   typedef struct packed {
      base_type     base;
      logic [62:0]  s;
      div_lane_type lx;
      div_lane_type ly;
   } div_stage_type;

   // digit-by-digit square root lane
   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] op;
   } sqrt_lane_type;

   typedef struct packed {
      base_type      base;
      sqrt_lane_type lx;
      sqrt_lane_type ly;
   } sqrt_stage_type;

   // finished item: offset magnitudes
   typedef struct packed {
      base_type    base;
      logic [31:0] mx;
      logic [31:0] my;
   } done_type;

   function automatic div_lane_type div_step(div_lane_type lane, logic [62:0] s);
      div_lane_type nxt;
      logic [63:0]  t;
      logic         qbit;
      t    = {lane.r, lane.qr[63]};
      qbit = (t >= {1'b0, s});
      if (qbit) begin
         nxt.r = 63'(t - {1'b0, s});
      end else begin
         nxt.r = t[62:0];
      end
      nxt.qr = {lane.qr[62:0], qbit};
      return nxt;
   endfunction

   function automatic sqrt_lane_type sqrt_step(sqrt_lane_type lane);
      sqrt_lane_type nxt;
      logic [35:0]   rs;
      logic [35:0]   trial;
      rs    = {lane.rem, lane.op[63:62]};
      trial = {2'b00, lane.root, 2'b01};
      if (rs >= trial) begin
         nxt.rem  = 34'(rs - trial);
         nxt.root = {lane.root[30:0], 1'b1};
      end else begin
         nxt.rem  = rs[33:0];
         nxt.root = {lane.root[30:0], 1'b0};
      end
      nxt.op = {lane.op[61:0], 2'b00};
      return nxt;
   endfunction

   // base plus or minus magnitude, clamped to the int32 range
   function automatic logic signed [31:0] sat_corner(logic signed [31:0] b,
                                                    logic [31:0] m, logic sub);
      logic [33:0] bb;
      logic [33:0] mm;
      logic [33:0] sum;
      bb  = {{2{b[31]}}, b};
      mm  = {2'b00, m};
      sum = sub ? (bb - mm) : (bb + mm);
      if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
         return sum[31:0];
      end else if (sum[33]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7FFF_FFFF;
      end
   endfunction

endpackage

`default_nettype wire

### hdl/srq_front.sv
`default_nettype none

module srq_front (
   input  wire srq_pkg::req_type item,
   output srq_pkg::job_type      job
);

   logic [32:0] dx;
   logic [32:0] dy;
   logic [32:0] adx;
   logic [32:0] ady;
   logic        big;

   // form the exact span and its magnitudes
   assign dx  = {item.end_x[31], item.end_x} - {item.start_x[31], item.start_x};
   assign dy  = {item.end_y[31], item.end_y} - {item.start_y[31], item.start_y};
   assign adx = dx[32] ? (33'd0 - dx) : dx;
   assign ady = dy[32] ? (33'd0 - dy) : dy;
   assign big = adx[32] | adx[31] | ady[32] | ady[31];

   // classify and pack the item for the back end
   always_comb begin
      job.base.sx     = item.start_x;
      job.base.sy     = item.start_y;
      job.base.sz     = item.start_z;
      job.base.ex     = item.end_x;
      job.base.ey     = item.end_y;
      job.base.ez     = item.end_z;
      job.base.ok     = !item.half_width[31] && (item.half_width != 32'sd0)
                        && ((dx != 33'd0) || (dy != 33'd0));
      job.base.neg_ox = !dy[32] && (dy != 33'd0);
      job.base.neg_oy = dx[32];
      job.ax          = big ? adx[31:1] : adx[30:0];
      job.ay          = big ? ady[31:1] : ady[30:0];
      job.w           = item.half_width[30:0];
   end

endmodule

`default_nettype wire

### hdl/srq_queue.sv
`default_nettype none

module srq_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  wire srq_pkg::job_type push_data,
   output logic                  full,
   input  wire                   pop,
   output srq_pkg::job_type      pop_data,
   output logic                  empty
);

   srq_pkg::job_type            mem_ff [srq_pkg::QUEUE_DEPTH];
   logic [srq_pkg::QPTR_W-1:0]  wr_ff;
   logic [srq_pkg::QPTR_W-1:0]  rd_ff;
   logic [srq_pkg::QPTR_W:0]    cnt_ff;
   logic                        do_push;
   logic                        do_pop;

   assign full     = (cnt_ff == (srq_pkg::QPTR_W+1)'(srq_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // store the item
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/srq_back.sv
`default_nettype none

module srq_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   input  wire srq_pkg::job_type in_job,
   output logic                  in_take,
   output logic                  out_valid,
   output srq_pkg::done_type     out_done,
   input  wire                   out_take
);

   logic                        en;

   // products of magnitude and width, and the squares
   logic                        s1_v_ff;
   srq_pkg::base_type           s1_base_ff;
   logic [61:0]                 px_ff;
   logic [61:0]                 py_ff;
   logic [61:0]                 sqa_ff;
   logic [61:0]                 sqb_ff;

   // partial products of the squared numerators
   logic                        s2_v_ff;
   srq_pkg::base_type           s2_base_ff;
   logic [61:0]                 hhx_ff, hlx_ff, llx_ff;
   logic [61:0]                 hhy_ff, hly_ff, lly_ff;
   logic [62:0]                 s_ff;

   logic [125:0]                nx;
   logic [125:0]                ny;
   srq_pkg::div_stage_type      div_in;
   srq_pkg::sqrt_stage_type     sqrt_in;

   logic [srq_pkg::DIV_STEPS:0]  dv_ff;
   srq_pkg::div_stage_type       d_ff [srq_pkg::DIV_STEPS+1];
   logic [srq_pkg::SQRT_STEPS:0] qv_ff;
   srq_pkg::sqrt_stage_type      q_ff [srq_pkg::SQRT_STEPS+1];

   // the whole pipeline moves together unless the last stage is held
   assign en        = !qv_ff[srq_pkg::SQRT_STEPS] || out_take;
   assign in_take   = en && in_valid;
   assign out_valid = qv_ff[srq_pkg::SQRT_STEPS];

   // numerator 4*(a*w)^2 from the split partial products
   always_comb begin
      nx = {hhx_ff, 64'd0} + {30'd0, hlx_ff, 34'd0} + {62'd0, llx_ff, 2'b00};
      ny = {hhy_ff, 64'd0} + {30'd0, hly_ff, 34'd0} + {62'd0, lly_ff, 2'b00};
      div_in.base  = s2_base_ff;
      div_in.s     = s_ff;
      div_in.lx.r  = {1'b0, nx[125:64]};
      div_in.lx.qr = nx[63:0];
      div_in.ly.r  = {1'b0, ny[125:64]};
      div_in.ly.qr = ny[63:0];
   end

   // start the root on the quotients
   always_comb begin
      sqrt_in.base    = d_ff[srq_pkg::DIV_STEPS].base;
      sqrt_in.lx.rem  = '0;
      sqrt_in.lx.root = '0;
      sqrt_in.lx.op   = d_ff[srq_pkg::DIV_STEPS].lx.qr;
      sqrt_in.ly.rem  = '0;
      sqrt_in.ly.root = '0;
      sqrt_in.ly.op   = d_ff[srq_pkg::DIV_STEPS].ly.qr;
   end

   // round the root halves: magnitude = (root + 1) / 2
   always_comb begin
      out_done.base = q_ff[srq_pkg::SQRT_STEPS].base;
      out_done.mx   = 32'(({1'b0, q_ff[srq_pkg::SQRT_STEPS].lx.root} + 33'd1) >> 1);
      out_done.my   = 32'(({1'b0, q_ff[srq_pkg::SQRT_STEPS].ly.root} + 33'd1) >> 1);
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         dv_ff   <= '0;
         qv_ff   <= '0;
      end else if (en) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         dv_ff   <= {dv_ff[srq_pkg::DIV_STEPS-1:0], s2_v_ff};
         qv_ff   <= {qv_ff[srq_pkg::SQRT_STEPS-1:0], dv_ff[srq_pkg::DIV_STEPS]};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_base_ff <= in_job.base;
         px_ff      <= {31'd0, in_job.ay} * {31'd0, in_job.w};
         py_ff      <= {31'd0, in_job.ax} * {31'd0, in_job.w};
         sqa_ff     <= {31'd0, in_job.ax} * {31'd0, in_job.ax};
         sqb_ff     <= {31'd0, in_job.ay} * {31'd0, in_job.ay};

         s2_base_ff <= s1_base_ff;
         hhx_ff     <= {31'd0, px_ff[61:31]} * {31'd0, px_ff[61:31]};
         hlx_ff     <= {31'd0, px_ff[61:31]} * {31'd0, px_ff[30:0]};
         llx_ff     <= {31'd0, px_ff[30:0]} * {31'd0, px_ff[30:0]};
         hhy_ff     <= {31'd0, py_ff[61:31]} * {31'd0, py_ff[61:31]};
         hly_ff     <= {31'd0, py_ff[61:31]} * {31'd0, py_ff[30:0]};
         lly_ff     <= {31'd0, py_ff[30:0]} * {31'd0, py_ff[30:0]};
         s_ff       <= {1'b0, sqa_ff} + {1'b0, sqb_ff};

         d_ff[0] <= div_in;
         for (int i = 0; i < srq_pkg::DIV_STEPS; i++) begin
            d_ff[i+1].base <= d_ff[i].base;
            d_ff[i+1].s    <= d_ff[i].s;
            d_ff[i+1].lx   <= srq_pkg::div_step(d_ff[i].lx, d_ff[i].s);
            d_ff[i+1].ly   <= srq_pkg::div_step(d_ff[i].ly, d_ff[i].s);
         end

         q_ff[0] <= sqrt_in;
         for (int i = 0; i < srq_pkg::SQRT_STEPS; i++) begin
            q_ff[i+1].base <= q_ff[i].base;
            q_ff[i+1].lx   <= srq_pkg::sqrt_step(q_ff[i].lx);
            q_ff[i+1].ly   <= srq_pkg::sqrt_step(q_ff[i].ly);
         end
      end
   end

endmodule

`default_nettype wire

### hdl/srq_emit.sv
`default_nettype none

module srq_emit (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   input  wire srq_pkg::done_type in_done,
   output logic                   take,
   output logic                   rsp_empty,
   input  wire                    rsp_pop,
   output srq_pkg::rsp_type       rsp_data
);

   logic              hv_ff;
   logic [1:0]        cnt_ff;
   srq_pkg::done_type hold_ff;
   logic              is_last;
   logic              at_end;
   logic              plus;
   logic signed [31:0] bx, by, bz;

   assign rsp_empty = !hv_ff;
   assign is_last   = !hold_ff.base.ok || (cnt_ff == srq_pkg::CORNER_LAST);
   assign take      = !hv_ff || (rsp_pop && is_last);
   assign at_end    = (cnt_ff == 2'd1) || (cnt_ff == 2'd2);
   assign plus      = cnt_ff[1];
   assign bx        = at_end ? hold_ff.base.ex : hold_ff.base.sx;
   assign by        = at_end ? hold_ff.base.ey : hold_ff.base.sy;
   assign bz        = at_end ? hold_ff.base.ez : hold_ff.base.sz;

   // form the current corner
   always_comb begin
      if (hold_ff.base.ok) begin
         rsp_data.corner_x     = srq_pkg::sat_corner(bx, hold_ff.mx,
                                                     plus == hold_ff.base.neg_ox);
         rsp_data.corner_y     = srq_pkg::sat_corner(by, hold_ff.my,
                                                     plus == hold_ff.base.neg_oy);
         rsp_data.corner_z     = bz;
         rsp_data.corner_index = cnt_ff;
         rsp_data.valid_res    = 1'b1;
         rsp_data.last         = (cnt_ff == srq_pkg::CORNER_LAST);
      end else begin
         rsp_data.corner_x     = '0;
         rsp_data.corner_y     = '0;
         rsp_data.corner_z     = '0;
         rsp_data.corner_index = '0;
         rsp_data.valid_res    = 1'b0;
         rsp_data.last         = 1'b1;
      end
   end

   // load a finished item or step through its corners
   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff  <= 1'b0;
         cnt_ff <= '0;
      end else if (take) begin
         hv_ff  <= in_valid;
         cnt_ff <= '0;
      end else if (rsp_pop) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // hold the item payload
   always_ff @(posedge clock) begin
      if (take) begin
         hold_ff <= in_done;
      end
   end

endmodule

`default_nettype wire

### hdl/segment_ribbon_quad.sv
// Channel   Direction  Handshake          Payload
// req_      in         req_push/req_full  srq_pkg::req_type (segment, half width)
// rsp_      out        rsp_pop/rsp_empty  srq_pkg::rsp_type (one corner)
//
// A good segment gives four corners, one per cycle while rsp_pop is high, and
// the next segment loads as the last pops; a degenerate one gives one result.
// The pipeline has two multiply stages, 65 divider stages (each but the first
// adds a quotient bit) and 33 square root stages, all but the first a root bit.
// Reset is synchronous and clears valid bits, pointers and counts, not data.
// While the corner register is held and a finished item waits at the pipeline
// end, the whole arithmetic pipeline halts; the queue fills and req_full rises.
`default_nettype none

module segment_ribbon_quad (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_push,
   output logic                  req_full,
   input  wire srq_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire                   rsp_pop,
   output srq_pkg::rsp_type      rsp_data
);

   srq_pkg::job_type  job;
   srq_pkg::job_type  q_job;
   logic              q_empty;
   logic              q_pop;
   logic              done_valid;
   srq_pkg::done_type done;
   logic              done_take;

   srq_front u_front (
      .item (req_data),
      .job  (job)
   );

   srq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (job),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_job),
      .empty     (q_empty)
   );

   srq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_job    (q_job),
      .in_take   (q_pop),
      .out_valid (done_valid),
      .out_done  (done),
      .out_take  (done_take)
   );

   srq_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (done_valid),
      .in_done   (done),
      .take      (done_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hdl/srq_checker.sv
`default_nettype none

module srq_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_push,
   input wire                   req_full,
   input wire srq_pkg::req_type req_data,
   input wire                   rsp_empty,
   input wire                   rsp_pop,
   input wire srq_pkg::rsp_type rsp_data
);

   // nothing to deliver right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled item changed");

   // a degenerate result is a lone zero item
   a_invalid: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.valid_res) |->
      (rsp_data.last && rsp_data.corner_index == 2'd0 && rsp_data.corner_x == 32'sd0))
      else $error("bad degenerate result");

   // last marks the fourth corner of a quad
   a_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.valid_res) |->
      (rsp_data.last == (rsp_data.corner_index == srq_pkg::CORNER_LAST)))
      else $error("last flag out of place");

   // corners follow one another with no gap
   a_next: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last) |=>
      (!rsp_empty && rsp_data.valid_res &&
       rsp_data.corner_index == $past(rsp_data.corner_index) + 2'd1))
      else $error("corner sequence broken");

endmodule

bind segment_ribbon_quad srq_checker u_srq_checker (.*);

`default_nettype wire
